// File: rtl/aeskx_pkg.sv
package aeskx_pkg;

  // schedule geometry
  localparam int unsigned NUM_WORDS = 44;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned WIN_DEPTH = 4;
  localparam int unsigned WIN_AW    = 2;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_WORDS - 1);
  localparam logic [7:0]       RCON_INIT = 8'h01;
  localparam logic [7:0]       GF_POLY   = 8'h1b;

  // standard aes forward s-box
  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sub_byte(input logic [7:0] b);
    return SBOX[b];
  endfunction

  // doubling in gf(2^8)
  function automatic logic [7:0] gf_double(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
  endfunction

endpackage

// File: rtl/aeskx_key_if.sv
interface aeskx_key_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_high;
  logic [63:0] key_low;

  modport source (output valid, output key_high, output key_low, input ready);
  modport sink   (input valid, input key_high, input key_low, output ready);
endinterface

// File: rtl/aeskx_word_if.sv
interface aeskx_word_if;
  logic        valid;
  logic        ready;
  logic [5:0]  word_index;
  logic [31:0] round_word;
  logic        last_word;

  modport source (output valid, output word_index, output round_word, output last_word,
                  input ready);
  modport sink   (input valid, input word_index, input round_word, input last_word,
                  output ready);
endinterface

// File: rtl/aeskx_round_fn.sv
module aeskx_round_fn (
  input  logic [31:0] prev,
  input  logic [7:0]  rcon,
  input  logic        apply,
  output logic [31:0] temp
);

  logic [31:0] rot;
  logic [31:0] sub;

  // rotword then subword
  assign rot = {prev[23:0], prev[31:24]};
  assign sub = {aeskx_pkg::sub_byte(rot[31:24]), aeskx_pkg::sub_byte(rot[23:16]),
                aeskx_pkg::sub_byte(rot[15:8]),  aeskx_pkg::sub_byte(rot[7:0])};

  // round constant goes into the top byte on every fourth word
  assign temp = apply ? (sub ^ {rcon, 24'h000000}) : prev;

endmodule

// File: rtl/aes128_key_expansion_unit.sv
// AES-128 key expansion: accepts one 128-bit key as two 64-bit halves (first key byte in the
// top bits of key_high) and delivers the 44 round-key words w0..w43 in order, each tagged with
// its index and with last_word set on w43. One word is produced per cycle while the output side
// takes them, and a key keeps the block busy from its acceptance until w43 has been computed;
// no new key is accepted meanwhile. The next key is accepted in the cycle after w43 has been
// computed, while w43 may still wait in the output register. The rate is set by the word
// recurrence: each word needs the word before it and the word four places back, which is read
// from a four-entry window memory into a register while the word before it is produced. No
// clearing pass after reset.
module aes128_key_expansion_unit (
  input  logic         clk,
  input  logic         rst,
  aeskx_key_if.sink    key,
  aeskx_word_if.source words
);

  logic                              busy;
  logic [aeskx_pkg::IDX_W-1:0]       idx;
  logic [7:0]                        rcon;
  logic [127:0]                      key_q;
  logic [aeskx_pkg::WORD_W-1:0]      prev;
  logic [aeskx_pkg::WORD_W-1:0]      rd_q;
  logic [aeskx_pkg::WORD_W-1:0]      win_mem [aeskx_pkg::WIN_DEPTH];
  logic                              out_valid;
  logic [aeskx_pkg::IDX_W-1:0]       out_index;
  logic [aeskx_pkg::WORD_W-1:0]      out_word;
  logic                              out_last;

  logic                              accept;
  logic                              adv;
  logic                              in_key;
  logic                              is_last;
  logic                              apply;
  logic [aeskx_pkg::WIN_AW-1:0]      wr_addr;
  logic [aeskx_pkg::WIN_AW-1:0]      rd_addr;
  logic [aeskx_pkg::WORD_W-1:0]      temp;
  logic [aeskx_pkg::WORD_W-1:0]      key_word;
  logic [aeskx_pkg::WORD_W-1:0]      word_next;

  // handshake and advance
  assign key.ready = !busy;
  assign accept    = key.valid && !busy;
  assign adv       = busy && (!out_valid || words.ready);

  assign in_key  = (idx[aeskx_pkg::IDX_W-1:2] == '0);
  assign is_last = (idx == aeskx_pkg::LAST_IDX);
  assign apply   = !in_key && (idx[1:0] == 2'd0);
  assign wr_addr = idx[aeskx_pkg::WIN_AW-1:0];
  assign rd_addr = wr_addr + 2'd1;

  aeskx_round_fn u_round_fn (
    .prev  (prev),
    .rcon  (rcon),
    .apply (apply),
    .temp  (temp)
  );

  // first four words come straight from the key
  always_comb begin
    case (idx[1:0])
      2'd0:    key_word = key_q[127:96];
      2'd1:    key_word = key_q[95:64];
      2'd2:    key_word = key_q[63:32];
      default: key_word = key_q[31:0];
    endcase
  end

  assign word_next = in_key ? key_word : (rd_q ^ temp);

  // window memory: write word i, read slot holding w[i-3] for the next word
  always_ff @(posedge clk) begin
    if (adv) begin
      win_mem[wr_addr] <= word_next;
      rd_q             <= win_mem[rd_addr];
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      rcon      <= aeskx_pkg::RCON_INIT;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        idx  <= '0;
        rcon <= aeskx_pkg::RCON_INIT;
      end else if (adv) begin
        busy <= !is_last;
        idx  <= is_last ? '0 : idx + 1'b1;
        if (apply) begin
          rcon <= aeskx_pkg::gf_double(rcon);
        end
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (words.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      key_q <= {key.key_high, key.key_low};
    end
    if (adv) begin
      prev      <= word_next;
      out_index <= idx;
      out_word  <= word_next;
      out_last  <= is_last;
    end
  end

  assign words.valid      = out_valid;
  assign words.word_index = out_index;
  assign words.round_word = out_word;
  assign words.last_word  = out_last;

`ifndef ASSERT_OFF
  // a new run starts at word zero
  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && idx == '0))
    else $error("run did not start at word zero");

  // the run ends right after the last word
  a_end: assert property (@(posedge clk) disable iff (rst)
    (adv && is_last) |=> (!busy && out_valid && out_last))
    else $error("run did not end after the last word");

  // idle sequencer sits at word zero
  a_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (idx == '0))
    else $error("idle with nonzero word index");

  // last flag only on the final index
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_index == aeskx_pkg::LAST_IDX)))
    else $error("last flag does not match index");
`endif

endmodule
